// ===== src/dhrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dhrt_pkg
// Shared types and constants for the dispatch handle remap table.
// ----------------------------------------------------------------------------
package dhrt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // item kinds
    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_SET_MAP  = 2'd1;
    localparam logic [1:0] KIND_PACKET   = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;

    localparam logic [7:0] PKT_KERNEL_DISPATCH = 8'd2;

    localparam logic [31:0] SWAP_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  packet_type;
        logic [63:0] handle;
        logic [63:0] real_handle;
        logic [31:0] private_size;
        logic [31:0] group_size;
        logic        batch_end;
    } t_in;

    typedef struct packed {
        logic [63:0] handle_out;
        logic [31:0] private_out;
        logic [31:0] group_out;
        logic        swapped;
        logic        known;
        logic [63:0] resolved_handle;
        logic [1:0]  status;
        logic [31:0] swaps_in_batch;
    } t_out;

    // per-entry payload kept in the data memory
    typedef struct packed {
        logic [63:0] real_handle;
        logic [31:0] private_size;
        logic [31:0] group_size;
    } t_entry;

    // tag lookup result
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] slot;
        logic             has_free;
        logic [IDX_W-1:0] free_slot;
    } t_lookup;

endpackage

// ===== src/dhrt_cam.sv =====
// ----------------------------------------------------------------------------
// dhrt_cam
// Tag store with valid bits: parallel match and lowest free slot search.
// ----------------------------------------------------------------------------
module dhrt_cam (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [63:0]           i_key,
    input  logic                  i_wr_en,
    input  logic [dhrt_pkg::IDX_W-1:0] i_wr_idx,
    output dhrt_pkg::t_lookup     o_look
);
    import dhrt_pkg::*;

    logic [63:0]              r_tag [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TABLE_ENTRIES-1:0] hit_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag[i_wr_idx] <= i_key;
        end
    end

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_tag[i] == i_key);
        end
    end

    // lowest index wins for both searches
    always_comb begin
        o_look = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                o_look.hit  = 1'b1;
                o_look.slot = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                o_look.has_free  = 1'b1;
                o_look.free_slot = IDX_W'(i);
            end
        end
    end

endmodule

// ===== src/dispatch_handle_remap_table.sv =====
// ----------------------------------------------------------------------------
// dispatch_handle_remap_table
// Maps 64-bit tag handles to real kernel handles and segment sizes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid/o_in_ready carries one item (t_in): register a
//   tag, set its real mapping, or pass a queue packet. Output channel
//   o_out_valid/i_out_ready carries exactly one result (t_out) per item.
//   Tags and valid bits live in a flop CAM (parallel compare, lowest free
//   slot); real handle and sizes live in a one-read, one-write-port synchronous memory.
//   Each item walks LOOK (CAM compare, memory read issue) and EXEC (read data
//   back, write-back, result formed) after being accepted in IDLE, and the
//   result is registered for o_out_valid when EXEC completes; the block takes
//   no new item until the last one has left EXEC.
//   The input is taken again while the previous result still waits in the
//   output register. If the receiver stalls and the output register is
//   full, EXEC holds (no write-back) until the result moves on.
//   Reset clears all valid bits and the swap counter; no clearing pass is
//   needed since unwritten memory entries are never read as valid.
//   The swap counter saturates and is reported/cleared on a batch-end packet.
// ----------------------------------------------------------------------------
module dispatch_handle_remap_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dhrt_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dhrt_pkg::t_out o_out
);
    import dhrt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } t_state;

    t_state           r_state;
    t_in              r_item;
    t_lookup          look;
    t_lookup          r_look;
    t_entry           r_mem [TABLE_ENTRIES];
    t_entry           r_rd;
    logic [31:0]      r_swaps;
    logic [31:0]      n_swaps;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;
    logic             proceed;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic             cam_we;

    dhrt_cam u_cam (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (r_item.handle),
        .i_wr_en  (cam_we),
        .i_wr_idx (r_look.free_slot),
        .o_look   (look)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign proceed     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // result and write-back, evaluated in EXEC
    always_comb begin
        n_out                 = '0;
        n_out.handle_out      = r_item.handle;
        n_out.private_out     = r_item.private_size;
        n_out.group_out       = r_item.group_size;
        n_out.known           = r_look.hit;
        n_out.resolved_handle = r_look.hit ? r_rd.real_handle : r_item.handle;
        n_out.status          = STAT_OK;
        n_swaps               = r_swaps;
        mem_we                = 1'b0;
        cam_we                = 1'b0;
        mem_waddr             = r_look.slot;
        mem_wdata             = '0;
        case (r_item.kind)
            KIND_REGISTER: begin
                if (!r_look.hit) begin
                    if (r_look.has_free) begin
                        cam_we                = proceed;
                        mem_we                = proceed;
                        mem_waddr             = r_look.free_slot;
                        n_out.known           = 1'b1;
                        n_out.resolved_handle = '0;
                    end else begin
                        n_out.status = STAT_FULL;
                    end
                end
            end
            KIND_SET_MAP: begin
                if (r_look.hit) begin
                    mem_we                 = proceed;
                    mem_wdata.real_handle  = r_item.real_handle;
                    mem_wdata.private_size = r_item.private_size;
                    mem_wdata.group_size   = r_item.group_size;
                    n_out.resolved_handle  = r_item.real_handle;
                end else begin
                    n_out.status = STAT_ABSENT;
                end
            end
            KIND_PACKET: begin
                if (r_item.packet_type == PKT_KERNEL_DISPATCH && r_look.hit &&
                    r_rd.real_handle != '0 && r_rd.real_handle != r_item.handle) begin
                    n_out.handle_out  = r_rd.real_handle;
                    n_out.private_out = r_rd.private_size;
                    n_out.group_out   = r_rd.group_size;
                    n_out.swapped     = 1'b1;
                    if (r_swaps != SWAP_MAX) begin
                        n_swaps = r_swaps + 32'd1;
                    end
                end
                if (r_item.batch_end) begin
                    n_out.swaps_in_batch = n_swaps;
                    n_swaps              = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_swaps     <= '0;
        end else begin
            // a new result refills the output register in the cycle it drains
            if (proceed) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (proceed) begin
                        r_swaps     <= n_swaps;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in;
        end
        if (r_state == S_LOOK) begin
            r_look <= look;
        end
        if (proceed) begin
            r_out <= n_out;
        end
    end

    // data memory: one read, one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_LOOK) begin
            r_rd <= r_mem[look.slot];
        end
    end

    // a rewritten packet always came from a known tag
    a_swap_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.swapped || r_out.known))
        else $error("swapped result without a known tag");

    // a full-table status never reports the tag as known
    a_full_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STAT_FULL) |-> !r_out.known)
        else $error("full status with known tag");

    // every accepted item passes LOOK and reaches EXEC
    a_item_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 (r_state == S_EXEC))
        else $error("item did not reach EXEC");

    // the swap counter is cleared after a batch-end packet retires
    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proceed && r_item.kind == KIND_PACKET && r_item.batch_end) |=> (r_swaps == '0))
        else $error("swap counter not cleared at batch end");

endmodule

// ===== tb/dhrt_checker.sv =====
// ----------------------------------------------------------------------------
// dhrt_checker
// Watches both channels of the remap table, predicts each result from its own
// copy of the tag table and swap counter, and compares every field.
// ----------------------------------------------------------------------------
module dhrt_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  dhrt_pkg::t_in  i_in,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  dhrt_pkg::t_out i_out,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_result_count,
    output int             o_swap_count,
    output int             o_full_count,
    output int             o_absent_count
);
    import dhrt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        tbl_valid [TABLE_ENTRIES];
    logic [63:0] tbl_tag [TABLE_ENTRIES];
    logic [63:0] tbl_real [TABLE_ENTRIES];
    logic [31:0] tbl_priv [TABLE_ENTRIES];
    logic [31:0] tbl_grp [TABLE_ENTRIES];
    logic [31:0] batch_swaps;
    t_out        expected_results [$];

    function automatic int find_tag(logic [63:0] tag);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_tag[i] == tag) return i;
        end
        return -1;
    endfunction

    function automatic t_out remap_item(t_in it);
        t_out r;
        int   slot;
        int   f;
        slot = find_tag(it.handle);
        r = '0;
        r.handle_out  = it.handle;
        r.private_out = it.private_size;
        r.group_out   = it.group_size;
        r.status      = STAT_OK;
        if (it.kind == KIND_REGISTER) begin
            if (slot < 0) begin
                f = -1;
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                    if (!tbl_valid[i]) f = i;
                end
                if (f < 0) begin
                    r.status = STAT_FULL;
                end else begin
                    tbl_valid[f] = 1'b1;
                    tbl_tag[f]   = it.handle;
                    tbl_real[f]  = '0;
                    tbl_priv[f]  = '0;
                    tbl_grp[f]   = '0;
                    slot = f;
                end
            end
        end else if (it.kind == KIND_SET_MAP) begin
            if (slot < 0) begin
                r.status = STAT_ABSENT;
            end else begin
                tbl_real[slot] = it.real_handle;
                tbl_priv[slot] = it.private_size;
                tbl_grp[slot]  = it.group_size;
            end
        end else if (it.kind == KIND_PACKET) begin
            if (it.packet_type == PKT_KERNEL_DISPATCH && slot >= 0 &&
                tbl_real[slot] != '0 && tbl_real[slot] != it.handle) begin
                r.handle_out  = tbl_real[slot];
                r.private_out = tbl_priv[slot];
                r.group_out   = tbl_grp[slot];
                r.swapped     = 1'b1;
                if (batch_swaps != SWAP_MAX) batch_swaps++;
            end
            if (it.batch_end) begin
                r.swaps_in_batch = batch_swaps;
                batch_swaps = '0;
            end
        end
        r.known           = (slot >= 0);
        r.resolved_handle = (slot >= 0) ? tbl_real[slot] : it.handle;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
            batch_swaps = '0;
            expected_results.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
            o_swap_count   <= 0;
            o_full_count   <= 0;
            o_absent_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                exp_r = remap_item(i_in);
                expected_results.push_back(exp_r);
            end
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (i_out.swapped) o_swap_count <= o_swap_count + 1;
                if (i_out.status == STAT_FULL) o_full_count <= o_full_count + 1;
                if (i_out.status == STAT_ABSENT) o_absent_count <= o_absent_count + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result %h", i_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== i_out) begin
                        if (o_fail_count < 10) begin
                            $display("ERROR: result mismatch at %0t", $realtime);
                            $display("  exp h=%h p=%h g=%h sw=%b kn=%b rs=%h st=%0d b=%0d",
                                exp_r.handle_out, exp_r.private_out, exp_r.group_out,
                                exp_r.swapped, exp_r.known, exp_r.resolved_handle,
                                exp_r.status, exp_r.swaps_in_batch);
                            $display("  got h=%h p=%h g=%h sw=%b kn=%b rs=%h st=%0d b=%0d",
                                i_out.handle_out, i_out.private_out, i_out.group_out,
                                i_out.swapped, i_out.known, i_out.resolved_handle,
                                i_out.status, i_out.swaps_in_batch);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/dispatch_handle_remap_table_tb.sv =====
// ----------------------------------------------------------------------------
// dispatch_handle_remap_table_tb
// Drives register, set-mapping and packet transfers into the remap table with
// random gaps and stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module dispatch_handle_remap_table_tb;
    import dhrt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_item;

    int fail_count, pending, result_count, swap_count, full_count, absent_count;
    int cycle_count = 0;
    bit long_holdoff = 1'b0;

    // tags handed out so far; random traffic mostly reuses them
    logic [63:0] tag_pool [$];

    always #1 i_clk = ~i_clk;

    dispatch_handle_remap_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item)
    );

    dhrt_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in          (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out         (out_item),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_swap_count  (swap_count),
        .o_full_count  (full_count),
        .o_absent_count(absent_count)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stall per transfer, plus one long hold-off on request.
    initial begin
        int wait_cycles;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_holdoff) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_holdoff = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            // hold ready until one transfer completes
            @(posedge i_clk iff out_valid && out_ready);
        end
    end

    // One transfer on the input side; gap drawn before valid rises.
    task automatic send_item(t_in it, int max_gap);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk iff in_ready);
    endtask

    function automatic t_in make_item(logic [1:0] kind, logic [7:0] ptype,
                                      logic [63:0] handle, logic [63:0] real_h,
                                      logic [31:0] psize, logic [31:0] gsize,
                                      logic bend);
        t_in it;
        it.kind = kind;
        it.packet_type = ptype;
        it.handle = handle;
        it.real_handle = real_h;
        it.private_size = psize;
        it.group_size = gsize;
        it.batch_end = bend;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_tag();
        if (tag_pool.size() == 0 || $urandom_range(0, 9) == 0) return rand64();
        return tag_pool[$urandom_range(0, tag_pool.size() - 1)];
    endfunction

    initial begin
        t_in         it;
        logic [63:0] tag;
        int          max_gap;
        int          phase;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every kind, each special case.
        send_item(make_item(KIND_PACKET, PKT_KERNEL_DISPATCH, '1, '1, '1, '1, 1'b1), 2);
        send_item(make_item(KIND_SET_MAP, 8'hFF, 64'h55, '1, '1, '1, 1'b0), 2);
        send_item(make_item(KIND_REGISTER, 8'h00, '0, '0, '0, '0, 1'b1), 2);
        send_item(make_item(KIND_REGISTER, 8'h00, '1, '0, '1, '1, 1'b0), 2);
        send_item(make_item(KIND_REGISTER, 8'h00, '1, '1, '0, '0, 1'b0), 2);
        // unmapped tag: no swap
        send_item(make_item(KIND_PACKET, PKT_KERNEL_DISPATCH, '1, '0, 32'h1, 32'h2, 1'b0), 2);
        send_item(make_item(KIND_SET_MAP, 8'h00, '1, 64'hAAAA_5555_0F0F_F0F0,
                            32'hDEAD_BEEF, 32'h1234_5678, 1'b0), 2);
        send_item(make_item(KIND_PACKET, PKT_KERNEL_DISPATCH, '1, '0, '0, '0, 1'b0), 2);
        // non-dispatch type: passes unswapped and ends the batch
        send_item(make_item(KIND_PACKET, 8'hFD, '1, '0, '0, '0, 1'b1), 2);
        // real handle equal to tag: no swap
        send_item(make_item(KIND_SET_MAP, 8'h00, '0, '0, '1, '1, 1'b1), 2);
        send_item(make_item(KIND_PACKET, PKT_KERNEL_DISPATCH, '0, '1, '1, '1, 1'b1), 2);
        send_item(make_item(KIND_SET_MAP, 8'h00, '1, '1, '1, '1, 1'b0), 2);
        send_item(make_item(KIND_PACKET, PKT_KERNEL_DISPATCH, '1, '0, '0, '0, 1'b1), 2);
        // unused kind
        send_item(make_item(KIND_RESERVED, PKT_KERNEL_DISPATCH, '1, '1, '1, '1, 1'b1), 2);
        // fill the table; the last two of these registers and one more overflow
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tag = 64'h1000 + i;
            tag_pool.push_back(tag);
            send_item(make_item(KIND_REGISTER, 8'h00, tag, '0, '0, '0, 1'b0), 0);
        end
        send_item(make_item(KIND_REGISTER, 8'h00, 64'hFEED, '0, '0, '0, 1'b0), 0);
        tag_pool.push_back('1);
        tag_pool.push_back('0);

        // Random: mostly map-then-dispatch traffic over known tags.
        for (int n = 0; n < 800; n++) begin
            phase = n / 100;
            max_gap = (phase % 3 == 2) ? 0 : 16;
            // long receiver hold-off while the sender keeps going
            if (n == 300) long_holdoff = 1'b1;
            tag = pick_tag();
            case ($urandom_range(0, 9))
                0: it = make_item(KIND_REGISTER, 8'($urandom), tag, rand64(),
                                  $urandom, $urandom, 1'($urandom_range(0, 1)));
                1, 2: it = make_item(KIND_SET_MAP, 8'($urandom), tag,
                                     ($urandom_range(0, 7) == 0) ? 64'h0 :
                                     ($urandom_range(0, 7) == 0) ? tag : rand64(),
                                     $urandom, $urandom, 1'($urandom_range(0, 1)));
                3: it = make_item(2'($urandom_range(0, 3)), 8'($urandom), rand64(),
                                  rand64(), $urandom, $urandom,
                                  1'($urandom_range(0, 1)));
                default: it = make_item(KIND_PACKET,
                                        ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                                        PKT_KERNEL_DISPATCH,
                                        tag, rand64(), $urandom, $urandom,
                                        ($urandom_range(0, 5) == 0));
            endcase
            send_item(it, max_gap);
        end
        in_valid <= 1'b0;

        // let the checker log the last transfer before draining
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        $display("%0d results checked: %0d swaps, %0d table-full, %0d absent-tag",
                 result_count, swap_count, full_count, absent_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("simulation failed");
        end
        $finish;
    end
endmodule
